@@ sv/bbrf_pkg.sv @@
// Package for the burst byte ring FIFO: widths, command codes and the
// structs passed between the pipeline stages. No dependencies.
package bbrf_pkg;

    // Fixed widths of the item fields.
    localparam int CMD_W  = 2;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int FILL_W = 9;

    // Byte lanes that one item spans, and the lane select width.
    localparam int LANES     = 8;
    localparam int LANE_BITS = 3;

    // Longest burst accepted, and the default ring size in bytes.
    localparam int MAX_BURST    = 8;
    localparam int CAPACITY_DEF = 256;

    // Command codes carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    // One byte from each lane, lane i in bits 8i+7:8i.
    typedef logic [LANES-1:0][7:0] t_lane_vec;

    // What the decision stage hands to the merge stage.
    typedef struct packed {
        logic                 status;
        logic [LEN_W-1:0]     done_count;
        logic [LEN_W-1:0]     rd_count;
        logic [LANE_BITS-1:0] rot;
        logic [FILL_W-1:0]    fill;
    } t_s1;

    // A finished result item.
    typedef struct packed {
        logic              status;
        logic [LEN_W-1:0]  done_count;
        logic [DATA_W-1:0] read_data;
        logic [FILL_W-1:0] fill_level;
    } t_rsp;

endpackage

@@ sv/bbrf_cmd_if.sv @@
// Command channel of the burst byte ring FIFO: valid, ready and one item.
// Depends on bbrf_pkg for the field widths.
interface bbrf_cmd_if;
    import bbrf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  byte_count;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, cmd, byte_count, write_data, input ready);
    modport sink   (input valid, cmd, byte_count, write_data, output ready);
endinterface

@@ sv/bbrf_rsp_if.sv @@
// Response channel of the burst byte ring FIFO: valid, ready and one item.
// Depends on bbrf_pkg for the field widths.
interface bbrf_rsp_if;
    import bbrf_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [LEN_W-1:0]  done_count;
    logic [DATA_W-1:0] read_data;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, status, done_count, read_data, fill_level,
                    input ready);
    modport sink   (input valid, status, done_count, read_data, fill_level,
                    output ready);
endinterface

@@ sv/bbrf_lane.sv @@
// One byte lane of the ring: a memory bank with one write port and one
// registered read port. No package dependencies.
module bbrf_lane #(
    parameter int BANK_AW = 5
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [BANK_AW-1:0] i_wr_row,
    input  logic [7:0]         i_wr_data,
    input  logic               i_rd_en,
    input  logic [BANK_AW-1:0] i_rd_row,
    output logic [7:0]         o_rd_data
);

    logic [7:0] r_mem [2**BANK_AW];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/bbrf_merge.sv @@
// Merge stage: rotates the lane bytes so the oldest byte lands in bits 7:0
// and clears the lanes beyond the burst. Depends on bbrf_pkg.
module bbrf_merge (
    input  bbrf_pkg::t_lane_vec                  i_lane_data,
    input  logic [bbrf_pkg::LANE_BITS-1:0]       i_rot,
    input  logic [bbrf_pkg::LEN_W-1:0]           i_count,
    output logic [bbrf_pkg::DATA_W-1:0]          o_data
);
    import bbrf_pkg::*;

    t_lane_vec w_out;

    // Output byte k comes from the lane that held the k-th oldest byte.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (LEN_W'(k) < i_count) begin
                w_out[k] = i_lane_data[i_rot + LANE_BITS'(k)];
            end else begin
                w_out[k] = 8'h00;
            end
        end
    end

    assign o_data = w_out;

endmodule

@@ sv/burst_byte_ring_fifo.sv @@
// Burst byte ring FIFO: a ring of CAPACITY bytes (a power of two, at least
// eight) split over eight byte lanes, so a put, get or peek of up to eight
// bytes moves as a single item. One command item is taken every cycle while the
// response side keeps up; a result passes through the registered read of the
// lane banks and then the output register before it is returned.
// A burst of zero bytes, of more than eight, or one that does not fit the
// free space (put) or the stored bytes (get, peek) is rejected and changes
// nothing. The fill level reported is the count after the command.
// Depends on bbrf_pkg, bbrf_cmd_if, bbrf_rsp_if, bbrf_lane and bbrf_merge.
module burst_byte_ring_fifo #(
    parameter int CAPACITY = bbrf_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbrf_cmd_if.sink    i_cmd,
    bbrf_rsp_if.source  o_rsp
);
    import bbrf_pkg::*;

    localparam int PTR_W   = $clog2(CAPACITY);
    localparam int CNT_W   = PTR_W + 1;
    localparam int BANK_AW = (PTR_W > LANE_BITS) ? PTR_W - LANE_BITS : 1;

    // Ring pointers and full flag.
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic             r_full, n_full;

    // Pipeline stage and output register.
    logic      r_s1_valid;
    t_s1       r_s1, n_s1;
    logic      r_out_valid;
    t_rsp      r_out;

    logic      w_out_free;
    logic      w_accept;
    logic      w_advance;

    logic [CNT_W-1:0] w_fill;
    logic [CNT_W-1:0] w_free;
    logic [CNT_W-1:0] w_len;
    logic             w_len_ok;
    logic             w_put_ok;
    logic             w_read_ok;
    logic             w_get;

    logic [LANES-1:0]               w_wr_en;
    logic [LANES-1:0][BANK_AW-1:0]  w_wr_row;
    logic [LANES-1:0][7:0]          w_wr_data;
    logic [LANES-1:0][BANK_AW-1:0]  w_rd_row;
    t_lane_vec                      w_lane_data;
    logic [DATA_W-1:0]              w_merged;

    // Handshake: the stage moves when the output register is free.
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_advance   = r_s1_valid && w_out_free;
    assign i_cmd.ready = !r_s1_valid || w_out_free;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // Current fill level and free space.
    assign w_fill   = r_full ? CNT_W'(CAPACITY) : {1'b0, r_wp - r_rp};
    assign w_free   = CNT_W'(CAPACITY) - w_fill;
    assign w_len    = CNT_W'(i_cmd.byte_count);
    assign w_len_ok = (i_cmd.byte_count != '0) &&
                      (i_cmd.byte_count <= LEN_W'(MAX_BURST));

    // Command decision.
    always_comb begin
        w_put_ok  = 1'b0;
        w_read_ok = 1'b0;
        w_get     = 1'b0;
        unique case (t_cmd'(i_cmd.cmd))
            CMD_PUT: begin
                w_put_ok = w_len_ok && (w_len <= w_free);
            end
            CMD_GET: begin
                w_read_ok = w_len_ok && (w_len <= w_fill);
                w_get     = 1'b1;
            end
            CMD_PEEK: begin
                w_read_ok = w_len_ok && (w_len <= w_fill);
            end
            default: begin
                w_put_ok  = 1'b0;
            end
        endcase
    end

    // Pointer, flag and stage updates for the item being taken.
    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_full = r_full;
        n_s1.status     = !(w_put_ok || w_read_ok);
        n_s1.done_count = (w_put_ok || w_read_ok) ? i_cmd.byte_count : '0;
        n_s1.rd_count   = w_read_ok ? i_cmd.byte_count : '0;
        n_s1.rot        = r_rp[LANE_BITS-1:0];
        n_s1.fill       = FILL_W'(w_fill);
        if (w_put_ok) begin
            n_wp      = r_wp + PTR_W'(i_cmd.byte_count);
            n_full    = (w_fill + w_len) == CNT_W'(CAPACITY);
            n_s1.fill = FILL_W'(w_fill + w_len);
        end else if (w_read_ok && w_get) begin
            n_rp      = r_rp + PTR_W'(i_cmd.byte_count);
            n_full    = 1'b0;
            n_s1.fill = FILL_W'(w_fill - w_len);
        end
    end

    // Lane addressing: lane i holds the byte whose address ends in i.
    always_comb begin
        logic [LANE_BITS-1:0] v_wk;
        logic [LANE_BITS-1:0] v_rk;
        for (int i = 0; i < LANES; i++) begin
            v_wk = LANE_BITS'(i) - r_wp[LANE_BITS-1:0];
            v_rk = LANE_BITS'(i) - r_rp[LANE_BITS-1:0];
            w_wr_en[i]   = w_accept && w_put_ok && (LEN_W'(v_wk) < i_cmd.byte_count);
            w_wr_row[i]  = BANK_AW'((r_wp + PTR_W'(v_wk)) >> LANE_BITS);
            w_wr_data[i] = i_cmd.write_data[{v_wk, 3'b000} +: 8];
            w_rd_row[i]  = BANK_AW'((r_rp + PTR_W'(v_rk)) >> LANE_BITS);
        end
    end

    // Byte lanes.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bbrf_lane #(
            .BANK_AW (BANK_AW)
        ) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (w_wr_en[g]),
            .i_wr_row  (w_wr_row[g]),
            .i_wr_data (w_wr_data[g]),
            .i_rd_en   (w_accept),
            .i_rd_row  (w_rd_row[g]),
            .o_rd_data (w_lane_data[g])
        );
    end

    // Merge the lane bytes into burst order.
    bbrf_merge u_merge (
        .i_lane_data (w_lane_data),
        .i_rot       (r_s1.rot),
        .i_count     (r_s1.rd_count),
        .o_data      (w_merged)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_full      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_wp   <= n_wp;
                r_rp   <= n_rp;
                r_full <= n_full;
            end
            if (i_cmd.ready) begin
                r_s1_valid <= i_cmd.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (w_advance) begin
            r_out.status     <= r_s1.status;
            r_out.done_count <= r_s1.done_count;
            r_out.read_data  <= w_merged;
            r_out.fill_level <= r_s1.fill;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.done_count = r_out.done_count;
    assign o_rsp.read_data  = r_out.read_data;
    assign o_rsp.fill_level = r_out.fill_level;

    // The full flag only stands when the pointers meet.
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wp == r_rp))
        else $error("full flag set with unequal pointers");

    // A rejected item moves no bytes and returns no data.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |-> (o_rsp.done_count == '0 &&
                                           o_rsp.read_data == '0))
        else $error("rejected item carries bytes");

    // An item waiting in the stage is not dropped while the output stalls.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> r_s1_valid)
        else $error("stage item lost under stall");

    // While the stage holds an item under a stall, the ring takes nothing new.
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |-> !w_accept)
        else $error("item taken while the stage is stalled");

endmodule

@@ dv/burst_byte_ring_fifo_tb.sv @@
// Self-checking testbench for burst_byte_ring_fifo: directed and phased random
// put, get and peek bursts with random idling, checked against a byte ring predictor.
// Depends on bbrf_pkg, bbrf_cmd_if, bbrf_rsp_if and the burst_byte_ring_fifo RTL.
module burst_byte_ring_fifo_tb;
    import bbrf_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int PTR_W      = $clog2(CAP);
    localparam int N_RANDOM   = 850;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 16;

    // Command code outside the legal set.
    localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    // Byte ring predictor and the queue of results it still waits for.
    class ring_fifo_scoreboard;
        logic [7:0]       ring_bytes [CAP];
        logic [PTR_W-1:0] wr_ptr;
        logic [PTR_W-1:0] rd_ptr;
        bit               is_full;
        t_rsp             pending_rsp [$];
        int               mismatches;
        int               checked;
        int               put_ok;
        int               get_ok;
        int               peek_ok;
        int               rejected;
        int               fills;

        function new();
            wr_ptr     = '0;
            rd_ptr     = '0;
            is_full    = 1'b0;
            mismatches = 0;
            checked    = 0;
            put_ok     = 0;
            get_ok     = 0;
            peek_ok    = 0;
            rejected   = 0;
            fills      = 0;
        endfunction

        // Bytes currently stored in the ring.
        function int level();
            logic [PTR_W-1:0] diff;
            diff = wr_ptr - rd_ptr;
            if (is_full) return CAP;
            return int'(diff);
        endfunction

        // Apply one accepted command and queue the result it must produce.
        function void note_command(logic [CMD_W-1:0] op, logic [LEN_W-1:0] len,
                                   logic [DATA_W-1:0] wdata);
            int   fill;
            bit   ok;
            t_rsp r;
            fill = level();
            ok   = 1'b0;
            r    = '0;
            if (len != 0 && len <= MAX_BURST) begin
                case (op)
                    CMD_PUT: if (len <= CAP - fill) begin
                        for (int i = 0; i < len; i++)
                            ring_bytes[(wr_ptr + i) % CAP] = wdata[8*i +: 8];
                        wr_ptr = wr_ptr + len;
                        // Pointers meeting after a put means the ring is full.
                        if (wr_ptr == rd_ptr) begin
                            is_full = 1'b1;
                            fills++;
                        end
                        ok = 1'b1;
                        put_ok++;
                    end
                    CMD_GET, CMD_PEEK: if (len <= fill) begin
                        for (int i = 0; i < len; i++)
                            r.read_data[8*i +: 8] = ring_bytes[(rd_ptr + i) % CAP];
                        if (op == CMD_GET) begin
                            rd_ptr  = rd_ptr + len;
                            is_full = 1'b0;
                            get_ok++;
                        end else begin
                            peek_ok++;
                        end
                        ok = 1'b1;
                    end
                    default: ;
                endcase
            end
            if (!ok) rejected++;
            r.status     = !ok;
            r.done_count = ok ? len : '0;
            r.fill_level = FILL_W'(level());
            pending_rsp.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_response(t_rsp got);
            t_rsp want;
            checked++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d with none expected: ",
                              "status=%0d done=%0d data=%h fill=%0d"},
                             checked, got.status, got.done_count, got.read_data,
                             got.fill_level);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.done_count !== want.done_count ||
                got.read_data !== want.read_data ||
                got.fill_level !== want.fill_level) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d expected status=%0d done=%0d data=%h fill=%0d",
                             checked, want.status, want.done_count, want.read_data,
                             want.fill_level);
                    $display("       got                status=%0d done=%0d data=%h fill=%0d",
                             got.status, got.done_count, got.read_data, got.fill_level);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbrf_cmd_if cmd_if ();
    bbrf_rsp_if rsp_if ();

    ring_fifo_scoreboard sb;
    bit     no_idle     = 1'b0;
    bit     rsp_took    = 1'b0;
    int     rsp_hold    = 0;
    int     idle_cycles = 0;
    int     sent        = 0;
    t_phase phase       = PH_FILL;

    burst_byte_ring_fifo #(.CAPACITY(CAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle cycles drawn for one item on either side.
    function int draw_gap();
        if (no_idle) return 0;
        return $urandom_range(0, 4);
    endfunction

    // Response side stalls for the drawn number of cycles after each item.
    always @(negedge i_clk) begin : rsp_ready_drive
        int gap;
        gap = rsp_hold;
        if (rsp_took) gap = draw_gap();
        if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= gap - 1;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor both channels and watch for a stalled run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                sb.note_command(cmd_if.cmd, cmd_if.byte_count, cmd_if.write_data);
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_response('{rsp_if.status, rsp_if.done_count, rsp_if.read_data,
                                    rsp_if.fill_level});
            end
            rsp_took <= rsp_if.valid && rsp_if.ready;
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Present one item from a falling edge and hold it until it is taken.
    task automatic drive_item(logic [CMD_W-1:0] op, logic [LEN_W-1:0] len,
                              logic [DATA_W-1:0] wdata);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.cmd        <= op;
        cmd_if.byte_count <= len;
        cmd_if.write_data <= wdata;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        sent++;
    endtask

    task automatic send_item(logic [CMD_W-1:0] op, logic [LEN_W-1:0] len,
                             logic [DATA_W-1:0] wdata);
        @(negedge i_clk);
        drive_item(op, len, wdata);
    endtask

    // Stop sending until every expected result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Random part: fill the ring to capacity, drain it empty, then mix, and repeat.
    task automatic run_random(int count);
        logic [CMD_W-1:0]  op;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] wdata;
        int                fill;
        int                room;
        int                put_pct;
        int                mix_left;
        mix_left = 0;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_drained();
            @(negedge i_clk);
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            fill = sb.level();
            case (phase)
                PH_FILL:  if (fill == CAP && $urandom_range(0, 2) == 0) phase = PH_DRAIN;
                PH_DRAIN: if (fill == 0 && $urandom_range(0, 2) == 0) begin
                    phase    = PH_MIX;
                    mix_left = 40;
                end
                default: begin
                    if (mix_left == 0) phase = PH_FILL;
                    else mix_left--;
                end
            endcase
            wdata = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 8) begin
                // Noise: unknown command, zero length or an oversized burst.
                case ($urandom_range(0, 2))
                    0: begin
                        op  = CMD_BAD;
                        len = LEN_W'($urandom_range(0, 15));
                    end
                    1: begin
                        op  = CMD_W'($urandom_range(0, 2));
                        len = '0;
                    end
                    default: begin
                        op  = CMD_W'($urandom_range(0, 2));
                        len = LEN_W'($urandom_range(MAX_BURST + 1, 15));
                    end
                endcase
            end else begin
                put_pct = (phase == PH_FILL) ? 80 : (phase == PH_DRAIN) ? 15 : 45;
                if ($urandom_range(0, 99) < put_pct) op = CMD_PUT;
                else op = ($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_GET;
                // Sometimes take exactly what fits, so the ring hits full and empty.
                room = (op == CMD_PUT) ? CAP - fill : fill;
                if (room > 0 && $urandom_range(0, 3) == 0)
                    len = LEN_W'((room < MAX_BURST) ? room : MAX_BURST);
                else
                    len = LEN_W'($urandom_range(1, MAX_BURST));
            end
            drive_item(op, len, wdata);
        end
    endtask

    initial begin
        sb                = new();
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.cmd        = CMD_PUT;
        cmd_if.byte_count = '0;
        cmd_if.write_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Rejections on an empty ring and for malformed commands.
        send_item(CMD_GET, 1, '0);
        send_item(CMD_PEEK, 1, '0);
        send_item(CMD_PUT, 0, '1);
        send_item(CMD_PUT, MAX_BURST + 1, '1);
        send_item(CMD_PUT, 15, '1);
        send_item(CMD_BAD, 4, '1);

        // Puts at the data extremes; upper lanes of a short put are ignored.
        send_item(CMD_PUT, 8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_PUT, 1, 64'h0);
        send_item(CMD_PUT, 8, 64'h0123_4567_89AB_CDEF);
        send_item(CMD_PUT, 5, 64'hA5A5_5A5A_C3C3_3C3C);

        // Reads of every size class, including ones beyond the fill level.
        send_item(CMD_PEEK, 8, '0);
        send_item(CMD_PEEK, 1, '0);
        send_item(CMD_GET, 0, '0);
        send_item(CMD_PEEK, 15, '0);
        send_item(CMD_BAD, 0, '0);
        send_item(CMD_GET, 3, '0);
        send_item(CMD_GET, 8, '1);
        send_item(CMD_PEEK, 8, '0);
        send_item(CMD_GET, 8, '0);
        send_item(CMD_GET, 4, '0);
        send_item(CMD_PEEK, 3, '0);
        send_item(CMD_GET, 3, '0);
        send_item(CMD_GET, 1, '0);
        wait_drained();

        run_random(N_RANDOM);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display({"Covered %0d commands and %0d results: ",
                  "%0d puts, %0d gets, %0d peeks, %0d rejected"},
                 sent, sb.checked, sb.put_ok, sb.get_ok, sb.peek_ok, sb.rejected);
        $display("The ring reached full capacity %0d times; %0d mismatched results",
                 sb.fills, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
